### src/rlh_pkg.sv
// Package with the shared constants, types and state encoding of the hyperperiod block.
`timescale 1ns / 1ps

package rlh_pkg;

    localparam int LCM_BITS        = 63;
    localparam int IN_PERIOD_BITS  = 32;
    localparam int PERIOD_BITS_DEF = 32;
    localparam int DIV_CNT_BITS    = $clog2(LCM_BITS + 1);

    localparam logic [LCM_BITS-1:0] LCM_MAX = {LCM_BITS{1'b1}};
    localparam logic [LCM_BITS-1:0] LCM_ONE = {{(LCM_BITS-1){1'b0}}, 1'b1};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GCD,
        ST_GCD_WAIT,
        ST_DIV_WAIT,
        ST_MUL,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic start;
        logic short_op;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

### src/rlh_in_if.sv
// Input channel interface carrying one task period and its restart flag.
`timescale 1ns / 1ps

interface rlh_in_if;
    import rlh_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [IN_PERIOD_BITS-1:0] period;
    logic                      restart;

    modport source (output valid, output period, output restart, input ready);
    modport sink   (input valid, input period, input restart, output ready);
endinterface

### src/rlh_out_if.sv
// Output channel interface carrying the running hyperperiod and the overflow flag.
`timescale 1ns / 1ps

interface rlh_out_if;
    import rlh_pkg::*;

    logic                valid;
    logic                ready;
    logic [LCM_BITS-1:0] hyperperiod;
    logic                overflow;

    modport source (output valid, output hyperperiod, output overflow, input ready);
    modport sink   (input valid, input hyperperiod, input overflow, output ready);
endinterface

### src/rlh_divider.sv
// Bit-serial restoring divider shared by the remainder loop and the final quotient.
`timescale 1ns / 1ps

module rlh_divider #(
    parameter int SHORT_BITS = rlh_pkg::PERIOD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  rlh_pkg::div_req_t            req,
    input  logic [rlh_pkg::LCM_BITS-1:0] dividend,
    input  logic [rlh_pkg::LCM_BITS-1:0] divisor,
    output rlh_pkg::div_stat_t           stat,
    output logic [rlh_pkg::LCM_BITS-1:0] quotient,
    output logic [rlh_pkg::LCM_BITS-1:0] remainder
);
    import rlh_pkg::*;

    localparam int SHORT_SHIFT = LCM_BITS - SHORT_BITS;

    logic [LCM_BITS-1:0]     rem_reg, rem_next;
    logic [LCM_BITS-1:0]     quo_reg, quo_next;
    logic [LCM_BITS-1:0]     den_reg, den_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [LCM_BITS:0]       trial;
    logic [LCM_BITS:0]       diff;

    assign trial = {rem_reg, quo_reg[LCM_BITS-1]};
    assign diff  = trial - {1'b0, den_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = '0;
            den_next  = divisor;
            busy_next = 1'b1;
            if (req.short_op)
            begin
                quo_next = dividend << SHORT_SHIFT;
                cnt_next = DIV_CNT_BITS'(SHORT_BITS);
            end
            else
            begin
                quo_next = dividend;
                cnt_next = DIV_CNT_BITS'(LCM_BITS);
            end
        end
        else if (busy_reg)
        begin
            if (!diff[LCM_BITS])
            begin
                rem_next = diff[LCM_BITS-1:0];
                quo_next = {quo_reg[LCM_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[LCM_BITS-1:0];
                quo_next = {quo_reg[LCM_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - DIV_CNT_BITS'(1);
            if (cnt_reg == DIV_CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

### src/running_lcm_hyperperiod_top.sv
// Top level of the running hyperperiod block: sequencer, state and serial multiplier.
//
//   Channel   Direction   Payload                         Transfer
//   items     in          period[31:0], restart           valid && ready
//   results   out         hyperperiod[62:0], overflow     valid && ready
//
// An item with a zero period or a saturated value goes straight to the result; any other item
// runs the Euclid remainder steps, a final division and a serial multiply, and every division
// runs through the one bit-serial divider.
// Reset brings the running value to 1 and clears the overflow flag.
// The input is not ready while an item is being worked on; a finished result waits
// in the output register, and the next item can be taken while it waits.
// A further finished result holds the sequencer until the output register is free.
`timescale 1ns / 1ps

module running_lcm_hyperperiod_top #(
    parameter int PERIOD_BITS = rlh_pkg::PERIOD_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    rlh_in_if.sink    items,
    rlh_out_if.source results
);
    import rlh_pkg::*;

    localparam int IDX_BITS = $clog2(PERIOD_BITS);
    localparam logic [LCM_BITS-1:0] PER_MASK = LCM_MAX >> (LCM_BITS - PERIOD_BITS);

    state_t                 state_reg, state_next;
    logic [LCM_BITS-1:0]    lcm_reg, lcm_next;
    logic                   ovf_reg, ovf_next;
    logic                   out_valid_reg, out_valid_next;
    logic [LCM_BITS-1:0]    out_lcm_reg, out_lcm_next;
    logic                   out_ovf_reg, out_ovf_next;
    logic [LCM_BITS-1:0]    a_reg, a_next;
    logic [LCM_BITS-1:0]    b_reg, b_next;
    logic [PERIOD_BITS-1:0] per_reg, per_next;
    logic [LCM_BITS-1:0]    q_reg, q_next;
    logic [LCM_BITS-1:0]    acc_reg, acc_next;
    logic [IDX_BITS-1:0]    idx_reg, idx_next;
    logic                   first_reg, first_next;

    logic [LCM_BITS-1:0]    b_in;
    logic [LCM_BITS-1:0]    lcm_rst;
    logic                   ovf_rst;
    logic [LCM_BITS+1:0]    mul_sum;
    div_req_t               div_req;
    div_stat_t              div_stat;
    logic [LCM_BITS-1:0]    div_dividend;
    logic [LCM_BITS-1:0]    div_divisor;
    logic [LCM_BITS-1:0]    div_quo;
    logic [LCM_BITS-1:0]    div_rem;

    rlh_divider #(
        .SHORT_BITS (PERIOD_BITS)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (div_req),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .stat      (div_stat),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign b_in    = {{(LCM_BITS-IN_PERIOD_BITS){1'b0}}, items.period} & PER_MASK;
    assign lcm_rst = items.restart ? LCM_ONE : lcm_reg;
    assign ovf_rst = items.restart ? 1'b0 : ovf_reg;
    assign mul_sum = {1'b0, acc_reg, 1'b0}
                   + (per_reg[idx_reg] ? {2'b00, q_reg} : {(LCM_BITS+2){1'b0}});

    assign items.ready         = (state_reg == ST_IDLE);
    assign results.valid       = out_valid_reg;
    assign results.hyperperiod = out_lcm_reg;
    assign results.overflow    = out_ovf_reg;

    always_comb
    begin
        state_next     = state_reg;
        lcm_next       = lcm_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg;
        out_lcm_next   = out_lcm_reg;
        out_ovf_next   = out_ovf_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        per_next       = per_reg;
        q_next         = q_reg;
        acc_next       = acc_reg;
        idx_next       = idx_reg;
        first_next     = first_reg;
        div_req        = '0;
        div_dividend   = lcm_reg;
        div_divisor    = a_reg;

        if (results.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (items.valid)
                begin
                    lcm_next = lcm_rst;
                    ovf_next = ovf_rst;
                    if (b_in == '0 || ovf_rst)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        a_next     = lcm_rst;
                        b_next     = b_in;
                        per_next   = b_in[PERIOD_BITS-1:0];
                        first_next = 1'b1;
                        state_next = ST_GCD;
                    end
                end
            end
            ST_GCD:
            begin
                div_req.start = 1'b1;
                if (b_reg == '0)
                begin
                    div_req.short_op = 1'b0;
                    div_dividend     = lcm_reg;
                    div_divisor      = a_reg;
                    state_next       = ST_DIV_WAIT;
                end
                else
                begin
                    div_req.short_op = !first_reg;
                    div_dividend     = a_reg;
                    div_divisor      = b_reg;
                    state_next       = ST_GCD_WAIT;
                end
            end
            ST_GCD_WAIT:
            begin
                if (div_stat.done)
                begin
                    a_next     = b_reg;
                    b_next     = div_rem;
                    first_next = 1'b0;
                    state_next = ST_GCD;
                end
            end
            ST_DIV_WAIT:
            begin
                if (div_stat.done)
                begin
                    q_next     = div_quo;
                    acc_next   = '0;
                    idx_next   = IDX_BITS'(PERIOD_BITS - 1);
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (mul_sum[LCM_BITS+1:LCM_BITS] != 2'b00)
                begin
                    lcm_next   = LCM_MAX;
                    ovf_next   = 1'b1;
                    state_next = ST_FINISH;
                end
                else
                begin
                    acc_next = mul_sum[LCM_BITS-1:0];
                    if (idx_reg == '0)
                    begin
                        lcm_next   = mul_sum[LCM_BITS-1:0];
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        idx_next = idx_reg - IDX_BITS'(1);
                    end
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    out_valid_next = 1'b1;
                    out_lcm_next   = lcm_reg;
                    out_ovf_next   = ovf_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            lcm_reg       <= LCM_ONE;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lcm_reg       <= lcm_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_lcm_reg <= out_lcm_next;
        out_ovf_reg <= out_ovf_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        per_reg     <= per_next;
        q_reg       <= q_next;
        acc_reg     <= acc_next;
        idx_reg     <= idx_next;
        first_reg   <= first_next;
    end

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (items.valid && items.ready) |=> (state_reg != ST_IDLE))
        else $error("sequencer stayed idle after an input transfer");

    a_result_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> (results.hyperperiod != '0))
        else $error("zero hyperperiod presented");

    a_overflow_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.overflow) |-> (results.hyperperiod == LCM_MAX))
        else $error("overflow flagged without saturated value");

    a_running_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |-> (lcm_reg != '0 && q_reg != '0))
        else $error("zero operand in multiply phase");

endmodule
